// File: hdl/lac_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lac_pkg
// Shared types and constants of the logic analyser capture engine.
// ----------------------------------------------------------------------------
package lac_pkg;

  localparam int MAX_DEPTH    = 1024;
  localparam int ADDR_W       = $clog2(MAX_DEPTH);
  localparam int CNT_W        = ADDR_W + 1;
  localparam int SAMPLE_WIDTH = 64;
  localparam int TIME_WIDTH   = 64;
  localparam int MEM_W        = SAMPLE_WIDTH + TIME_WIDTH;
  localparam int PCT_W        = 7;
  localparam int PROD_W       = CNT_W + PCT_W;

  // floor(x / 100) = (x * RECIP) >> RECIP_SHIFT, exact for every depth*percent (x <= 102400)
  localparam int PCT_FULL     = 100;
  localparam int RECIP_SHIFT  = 24;
  localparam int RECIP        = ((1 << RECIP_SHIFT) + PCT_FULL - 1) / PCT_FULL;
  localparam int RECIP_W      = 18;
  localparam int MUL_W        = PROD_W + RECIP_W;

  localparam int DEPTH_RESET  = 1024;
  localparam int PCT_RESET    = 50;

  // configuration register indexes
  localparam logic CFG_DEPTH   = 1'b0;
  localparam logic CFG_PERCENT = 1'b1;

  // phase codes as seen on the result channel
  localparam logic [1:0] PHASE_PREFILL  = 2'd0;
  localparam logic [1:0] PHASE_ARMED    = 2'd1;
  localparam logic [1:0] PHASE_POST     = 2'd2;
  localparam logic [1:0] PHASE_COMPLETE = 2'd3;

  typedef enum logic [1:0] {
    MODE_FRAME  = 2'd0,
    MODE_REARM  = 2'd1,
    MODE_ENABLE = 2'd2,
    MODE_READ   = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t             mode;
    logic [63:0]       sample_data;
    logic [63:0]       sample_time;
    logic              trigger_hit;
    logic              enable_value;
    logic [9:0]        read_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        phase;
    logic              just_completed;
    logic [10:0]       frames_held;
    logic [9:0]        trigger_position_actual;
    logic              read_valid;
    logic [63:0]       read_data;
    logic [63:0]       read_time;
    logic              read_is_trigger;
  } out_item_t;

  // settings handed from the configuration block to the capture control
  typedef struct packed {
    logic              clear;
    logic              clear_armed;
    logic [CNT_W-1:0]  depth;
    logic [ADDR_W-1:0] trig_idx;
  } cfg_info_t;

  // per-item status produced by the capture control
  typedef struct packed {
    logic [1:0]        phase;
    logic              just_completed;
    logic [10:0]       frames_held;
    logic [9:0]        trigger_position_actual;
    logic              read_valid;
    logic              read_is_trigger;
  } status_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    logic [MEM_W-1:0]  wdata;
  } mem_req_t;

endpackage

// File: hdl/lac_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lac_ram
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module lac_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// File: hdl/lac_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lac_cfg
// Configuration registers and trigger index derivation.
// ----------------------------------------------------------------------------
module lac_cfg (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  logic [lac_pkg::CNT_W-1:0] cfg_wdata,
  output lac_pkg::cfg_info_t     info,
  output logic                   busy
);

  import lac_pkg::*;

  logic [CNT_W-1:0]  depth_r, depth_nxt;
  logic [PCT_W-1:0]  pct_r, pct_nxt;
  logic [CNT_W-1:0]  deff_r, deff_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [ADDR_W-1:0] ti_r, ti_nxt;
  logic              busy_r;
  logic [PCT_W-1:0]  peff;
  logic [MUL_W-1:0]  mul;
  logic [CNT_W-1:0]  quot;
  logic [CNT_W-1:0]  dmax;

  always_comb begin
    depth_nxt = depth_r;
    pct_nxt   = pct_r;
    if (cfg_we) begin
      if (cfg_index == CFG_DEPTH) begin
        depth_nxt = cfg_wdata;
      end else begin
        pct_nxt = cfg_wdata[PCT_W-1:0];
      end
    end
    // clamp depth and percent to their usable ranges
    if (depth_nxt < CNT_W'(2)) begin
      deff_nxt = CNT_W'(2);
    end else if (depth_nxt > CNT_W'(MAX_DEPTH)) begin
      deff_nxt = CNT_W'(MAX_DEPTH);
    end else begin
      deff_nxt = depth_nxt;
    end
    peff     = (pct_nxt > PCT_W'(PCT_FULL)) ? PCT_W'(PCT_FULL) : pct_nxt;
    prod_nxt = PROD_W'(deff_nxt) * PROD_W'(peff);
  end

  // one multiply per register stage: product above, reciprocal here
  assign mul  = MUL_W'(prod_r) * MUL_W'(RECIP);
  assign quot = CNT_W'(mul >> RECIP_SHIFT);
  assign dmax = deff_r - CNT_W'(1);

  always_comb begin
    ti_nxt = (quot < dmax) ? quot[ADDR_W-1:0] : dmax[ADDR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= CNT_W'(DEPTH_RESET);
      pct_r   <= PCT_W'(PCT_RESET);
      deff_r  <= CNT_W'(DEPTH_RESET);
      prod_r  <= PROD_W'(DEPTH_RESET * PCT_RESET);
      ti_r    <= ADDR_W'(DEPTH_RESET * PCT_RESET / PCT_FULL);
      busy_r  <= 1'b0;
    end else begin
      depth_r <= depth_nxt;
      pct_r   <= pct_nxt;
      deff_r  <= deff_nxt;
      prod_r  <= prod_nxt;
      ti_r    <= ti_nxt;
      // hold off items until the new index has settled
      busy_r  <= cfg_we;
    end
  end

  assign info.clear       = cfg_we;
  // trigger index is zero exactly when depth*percent < 100
  assign info.clear_armed = prod_nxt < PROD_W'(PCT_FULL);
  assign info.depth       = deff_r;
  assign info.trig_idx    = ti_r;
  assign busy             = busy_r;

endmodule

// File: hdl/lac_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lac_ctrl
// Capture state machine: pointers, counts and window store requests.
// ----------------------------------------------------------------------------
module lac_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  lac_pkg::cfg_info_t info,
  input  logic               acc,
  input  lac_pkg::in_item_t  item,
  output lac_pkg::mem_req_t  req,
  output lac_pkg::status_t   status
);

  import lac_pkg::*;

  typedef enum logic [3:0] {
    PH_PREFILL  = 4'b0001,
    PH_ARMED    = 4'b0010,
    PH_POST     = 4'b0100,
    PH_COMPLETE = 4'b1000
  } phase_t;

  phase_t            phase_r, phase_nxt;
  logic [ADDR_W-1:0] wp_r, wp_nxt;
  logic [CNT_W-1:0]  hc_r, hc_nxt;
  logic [CNT_W-1:0]  pcl_r, pcl_nxt;
  logic [ADDR_W-1:0] tfi_r, tfi_nxt;
  logic [ADDR_W-1:0] ws_r, ws_nxt;
  logic              ten_r, ten_nxt;

  logic              do_clear;
  logic              clear_armed;
  logic              done;
  logic              rv;
  logic              rtrig;
  logic [CNT_W-1:0]  hc1;
  logic [CNT_W-1:0]  ti_ext;
  logic [CNT_W-1:0]  pcl_dec;
  logic [1:0]        phase_code;

  assign hc1    = hc_r + CNT_W'(1);
  assign ti_ext = CNT_W'(info.trig_idx);

  always_comb begin
    phase_nxt   = phase_r;
    wp_nxt      = wp_r;
    hc_nxt      = hc_r;
    pcl_nxt     = pcl_r;
    tfi_nxt     = tfi_r;
    ws_nxt      = ws_r;
    ten_nxt     = ten_r;
    do_clear    = 1'b0;
    clear_armed = (info.trig_idx == '0);
    done        = 1'b0;
    rv          = 1'b0;
    rtrig       = 1'b0;
    pcl_dec     = (pcl_r != '0) ? pcl_r - CNT_W'(1) : '0;
    req.we      = 1'b0;
    req.re      = 1'b0;
    req.addr    = wp_r;
    req.wdata   = {item.sample_data[SAMPLE_WIDTH-1:0], item.sample_time[TIME_WIDTH-1:0]};

    if (info.clear) begin
      do_clear    = 1'b1;
      clear_armed = info.clear_armed;
    end else if (acc) begin
      case (item.mode)
        MODE_FRAME: begin
          case (phase_r)
            PH_COMPLETE: begin
              // drop frames once the window is full
            end
            PH_POST: begin
              req.we  = 1'b1;
              wp_nxt  = ADDR_W'(wp_r + 1'b1);
              hc_nxt  = hc1;
              pcl_nxt = pcl_dec;
              if (pcl_dec == '0) begin
                phase_nxt = PH_COMPLETE;
                done      = 1'b1;
              end
            end
            default: begin
              if (ten_r && item.trigger_hit) begin
                // freeze history as the head of the window
                ws_nxt  = ADDR_W'(wp_r - hc_r[ADDR_W-1:0]);
                tfi_nxt = hc_r[ADDR_W-1:0];
                req.we  = 1'b1;
                wp_nxt  = ADDR_W'(wp_r + 1'b1);
                hc_nxt  = hc1;
                pcl_nxt = info.depth - hc1;
                if (info.depth == hc1) begin
                  phase_nxt = PH_COMPLETE;
                  done      = 1'b1;
                end else begin
                  phase_nxt = PH_POST;
                end
              end else begin
                if (info.trig_idx != '0) begin
                  req.we = 1'b1;
                  wp_nxt = ADDR_W'(wp_r + 1'b1);
                  hc_nxt = (hc1 > ti_ext) ? ti_ext : hc1;
                end
                phase_nxt = (hc_nxt >= ti_ext) ? PH_ARMED : PH_PREFILL;
              end
            end
          endcase
        end
        MODE_REARM: begin
          if (phase_r == PH_COMPLETE) begin
            do_clear = 1'b1;
          end
        end
        MODE_ENABLE: begin
          ten_nxt = item.enable_value;
          if (!item.enable_value && phase_r == PH_POST) begin
            do_clear = 1'b1;
          end
        end
        MODE_READ: begin
          if ((phase_r == PH_POST || phase_r == PH_COMPLETE) &&
              CNT_W'(item.read_index) < hc_r) begin
            req.re   = 1'b1;
            req.addr = ADDR_W'(ws_r + item.read_index);
            rv       = 1'b1;
            rtrig    = (item.read_index == tfi_r);
          end
        end
        default: begin
        end
      endcase
    end

    if (do_clear) begin
      wp_nxt    = '0;
      hc_nxt    = '0;
      pcl_nxt   = '0;
      tfi_nxt   = '0;
      ws_nxt    = '0;
      phase_nxt = clear_armed ? PH_ARMED : PH_PREFILL;
    end
  end

  always_comb begin
    case (phase_nxt)
      PH_PREFILL:  phase_code = PHASE_PREFILL;
      PH_ARMED:    phase_code = PHASE_ARMED;
      PH_POST:     phase_code = PHASE_POST;
      PH_COMPLETE: phase_code = PHASE_COMPLETE;
      default:     phase_code = PHASE_PREFILL;
    endcase
  end

  assign status.phase                   = phase_code;
  assign status.just_completed          = done;
  assign status.frames_held             = hc_nxt;
  assign status.trigger_position_actual = tfi_nxt;
  assign status.read_valid              = rv;
  assign status.read_is_trigger         = rtrig;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_PREFILL;
      wp_r    <= '0;
      hc_r    <= '0;
      pcl_r   <= '0;
      tfi_r   <= '0;
      ws_r    <= '0;
      ten_r   <= 1'b1;
    end else begin
      phase_r <= phase_nxt;
      wp_r    <= wp_nxt;
      hc_r    <= hc_nxt;
      pcl_r   <= pcl_nxt;
      tfi_r   <= tfi_nxt;
      ws_r    <= ws_nxt;
      ten_r   <= ten_nxt;
    end
  end

endmodule

// File: hdl/logic_analyzer_capture_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// logic_analyzer_capture_top
// Item status is registered in s1, then in out_r, which drives out_valid.
// Throughput: one item per cycle while in_ready is high; the window store
// takes one write or one read per cycle. A configuration write drops in_ready.
// Reset (synchronous, rst_n low): depth 1024, percent 50, trigger enabled,
// capture in prefill, pipeline empty. Window store contents are not cleared.
// ----------------------------------------------------------------------------
module logic_analyzer_capture_top (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  lac_pkg::in_item_t         in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output lac_pkg::out_item_t        out_data,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [lac_pkg::CNT_W-1:0] cfg_wdata
);

  import lac_pkg::*;

  cfg_info_t        info;
  logic             busy;
  logic             acc;
  mem_req_t         req;
  status_t          status;
  logic [MEM_W-1:0] rdata;

  logic             s1_valid_r, s1_valid_nxt;
  status_t          s1_stat_r;
  logic             s1_adv;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_r;

  lac_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .info      (info),
    .busy      (busy)
  );

  lac_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .info   (info),
    .acc    (acc),
    .item   (in_data),
    .req    (req),
    .status (status)
  );

  lac_ram #(
    .WIDTH (MEM_W),
    .DEPTH (MAX_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (req.we),
    .re    (req.re),
    .addr  (req.addr),
    .wdata (req.wdata),
    .rdata (rdata)
  );

  // read data is only reloaded on a new transfer, so it holds while s1 waits
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !busy && (!s1_valid_r || s1_adv);
  assign acc      = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_stat_r <= status;
    end
    if (s1_adv) begin
      out_r.phase                   <= s1_stat_r.phase;
      out_r.just_completed          <= s1_stat_r.just_completed;
      out_r.frames_held             <= s1_stat_r.frames_held;
      out_r.trigger_position_actual <= s1_stat_r.trigger_position_actual;
      out_r.read_valid              <= s1_stat_r.read_valid;
      out_r.read_is_trigger         <= s1_stat_r.read_is_trigger;
      out_r.read_data               <= s1_stat_r.read_valid ?
                                       64'(rdata[MEM_W-1 -: SAMPLE_WIDTH]) : '0;
      out_r.read_time               <= s1_stat_r.read_valid ?
                                       64'(rdata[TIME_WIDTH-1:0]) : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: hdl/lac_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lac_checker
// Port-level checks of the capture engine, bound to the top level.
// ----------------------------------------------------------------------------
module lac_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input lac_pkg::in_item_t         in_data,
  input logic                      out_valid,
  input logic                      out_ready,
  input lac_pkg::out_item_t        out_data,
  input logic                      cfg_we,
  input logic                      cfg_index,
  input logic [lac_pkg::CNT_W-1:0] cfg_wdata
);

  import lac_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // reads only hit once a window exists
  a_read_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.read_valid |->
      out_data.phase == PHASE_POST || out_data.phase == PHASE_COMPLETE)
    else $error("read hit outside a captured window");

  a_done_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.just_completed |-> out_data.phase == PHASE_COMPLETE)
    else $error("completion flagged without complete phase");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.read_valid |->
      out_data.read_data == '0 && out_data.read_time == '0 &&
      !out_data.read_is_trigger)
    else $error("read fields not cleared on a miss");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind logic_analyzer_capture_top lac_checker u_lac_checker (.*);
